@@ rtl/core/indexed_list_insert_erase_assert.svh @@
// Assertion macros used by the checker of the list block.
// Both macros expect signals named clk and rst in the scope where they are used.
`ifndef INDEXED_LIST_INSERT_ERASE_ASSERT_SVH
`define INDEXED_LIST_INSERT_ERASE_ASSERT_SVH

`define ILIE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define ILIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ilie_pkg.sv @@
package ilie_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int MODE_W  = 3;
  localparam int INDEX_W = 7;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef logic [MODE_W-1:0]         mode_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic [STAT_W-1:0]         status_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [DATA_WIDTH-1:0]     entry_t;

  localparam mode_t MODE_APPEND = 3'd0;
  localparam mode_t MODE_POP    = 3'd1;
  localparam mode_t MODE_INSERT = 3'd2;
  localparam mode_t MODE_ERASE  = 3'd3;
  localparam mode_t MODE_READ   = 3'd4;
  localparam mode_t MODE_FIRST  = 3'd5;
  localparam mode_t MODE_LAST   = 3'd6;
  localparam mode_t MODE_CLEAR  = 3'd7;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_RANGE = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;
  localparam status_t STATUS_FULL  = 2'd3;

  function automatic entry_t to_stored(word_t v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  function automatic word_t to_output(entry_t s);
    logic signed [DATA_WIDTH-1:0] ss;
    logic signed [63:0] w;
    ss = s;
    w = 64'(ss);
    return w[WORD_W-1:0];
  endfunction

endpackage

@@ rtl/core/ilie_if.sv @@
interface ilie_req_if import ilie_pkg::*; ();
  logic   valid;
  logic   ready;
  mode_t  mode;
  index_t index;
  word_t  value;

  modport source (output valid, output mode, output index, output value, input ready);
  modport sink (input valid, input mode, input index, input value, output ready);
  modport monitor (input valid, input ready, input mode, input index, input value);
endinterface

interface ilie_rsp_if import ilie_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   read_value;
  status_t status;
  count_t  count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink (input valid, input read_value, input status, input count, output ready);
  modport monitor (input valid, input ready, input read_value, input status, input count);
endinterface

@@ rtl/core/ilie_ram.sv @@
module ilie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/indexed_list_insert_erase.sv @@
// Append, remove last and clear go from idle straight to the done state, which loads the result.
// Reads at an index, first or last pass through a read issue and a read data state before done.
// Insert and erase move each entry by a read state and then a write state through the single
// RAM port pair; a failed check goes straight to done. One item is in work at a time.
// Ready for a new item rises in the same cycle the result is first offered; done waits for an
// earlier result to be taken. A synchronous reset empties the list and drops any pending result.
module indexed_list_insert_erase import ilie_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ilie_req_if.sink  req,
  ilie_rsp_if.source rsp
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MOVE_RD  = 3'd1;
  localparam logic [2:0] S_MOVE_WR  = 3'd2;
  localparam logic [2:0] S_RD_ISSUE = 3'd3;
  localparam logic [2:0] S_RD_DATA  = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ADDR_W-1:0] target, target_next;
  logic             dir_up, dir_up_next;
  entry_t           held, held_next;
  word_t            res_value, res_value_next;
  status_t          res_status, res_status_next;

  logic             rsp_valid, rsp_valid_next;
  word_t            rsp_value;
  status_t          rsp_status;
  count_t           rsp_count;
  logic             load_rsp;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  entry_t            ram_rdata;

  logic [ADDR_W-1:0] step;
  logic [CMP_W-1:0]  idx_w, cnt_w;
  logic              full, empty;

  ilie_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // The one pointer step serves both shift directions.
  assign step  = dir_up ? ptr - 1'b1 : ptr + 1'b1;
  assign idx_w = CMP_W'(req.index);
  assign cnt_w = CMP_W'(count);
  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.read_value = rsp_value;
  assign rsp.status     = rsp_status;
  assign rsp.count      = rsp_count;

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    target_next     = target;
    dir_up_next     = dir_up;
    held_next       = held;
    res_value_next  = res_value;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_waddr       = ptr;
    ram_wdata       = ram_rdata;
    ram_raddr       = ptr;
    load_rsp        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_status_next = STATUS_OK;
          res_value_next  = '0;
          state_next      = S_DONE;
          unique case (req.mode)
            MODE_APPEND: begin
              if (full) begin
                res_status_next = STATUS_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = ADDR_W'(count);
                ram_wdata  = to_stored(req.value);
                count_next = count + 1'b1;
              end
            end
            MODE_POP: begin
              if (!empty) begin
                count_next = count - 1'b1;
              end
            end
            MODE_INSERT: begin
              if (idx_w > cnt_w) begin
                res_status_next = STATUS_RANGE;
              end else if (full) begin
                res_status_next = STATUS_FULL;
              end else begin
                ptr_next    = ADDR_W'(count);
                target_next = ADDR_W'(req.index);
                held_next   = to_stored(req.value);
                dir_up_next = 1'b1;
                state_next  = S_MOVE_RD;
              end
            end
            MODE_ERASE: begin
              if (idx_w >= cnt_w) begin
                res_status_next = STATUS_RANGE;
              end else begin
                ptr_next    = ADDR_W'(req.index);
                target_next = ADDR_W'(count - 1'b1);
                dir_up_next = 1'b0;
                state_next  = S_MOVE_RD;
              end
            end
            MODE_READ: begin
              if (idx_w >= cnt_w) begin
                res_status_next = STATUS_RANGE;
              end else begin
                ptr_next   = ADDR_W'(req.index);
                state_next = S_RD_ISSUE;
              end
            end
            MODE_FIRST: begin
              if (empty) begin
                res_status_next = STATUS_EMPTY;
              end else begin
                ptr_next   = '0;
                state_next = S_RD_ISSUE;
              end
            end
            MODE_LAST: begin
              if (empty) begin
                res_status_next = STATUS_EMPTY;
              end else begin
                ptr_next   = ADDR_W'(count - 1'b1);
                state_next = S_RD_ISSUE;
              end
            end
            MODE_CLEAR: begin
              count_next = '0;
            end
          endcase
        end
      end
      S_MOVE_RD: begin
        if (ptr == target) begin
          if (dir_up) begin
            ram_we     = 1'b1;
            ram_wdata  = held;
            count_next = count + 1'b1;
          end else begin
            count_next = count - 1'b1;
          end
          state_next = S_DONE;
        end else begin
          ram_raddr  = step;
          state_next = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        ram_we     = 1'b1;
        ptr_next   = step;
        state_next = S_MOVE_RD;
      end
      S_RD_ISSUE: begin
        state_next = S_RD_DATA;
      end
      S_RD_DATA: begin
        res_value_next = to_output(ram_rdata);
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_rsp) begin
      rsp_valid_next = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    target     <= target_next;
    dir_up     <= dir_up_next;
    held       <= held_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    if (load_rsp) begin
      rsp_value  <= res_value;
      rsp_status <= res_status;
      rsp_count  <= COUNT_W'(count);
    end
  end

endmodule

@@ rtl/core/ilie_checker.sv @@
module ilie_checker import ilie_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    req_valid,
  input logic    req_ready,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input word_t   rsp_read_value,
  input status_t rsp_status,
  input count_t  rsp_count
);

`include "indexed_list_insert_erase_assert.svh"

  logic                             rsp_wait;
  logic                             req_take;
  logic                             rsp_fail;
  logic                             rsp_empty;
  logic                             rsp_full;
  logic [WORD_W+STAT_W+COUNT_W-1:0] rsp_payload;

  assign rsp_wait    = rsp_valid && !rsp_ready;
  assign req_take    = req_valid && req_ready;
  assign rsp_fail    = rsp_valid && (rsp_status != STATUS_OK);
  assign rsp_empty   = rsp_valid && (rsp_status == STATUS_EMPTY);
  assign rsp_full    = rsp_valid && (rsp_status == STATUS_FULL);
  assign rsp_payload = {rsp_read_value, rsp_status, rsp_count};

  `ILIE_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_payload), "Result changed.")
  `ILIE_ASSERT_NEXT(a_one_item, req_take, !req_ready, "Item taken while busy.")
  `ILIE_ASSERT_SAME(a_error_zero, rsp_fail, rsp_read_value == '0, "Nonzero value on error.")
  `ILIE_ASSERT_SAME(a_empty_count, rsp_empty, rsp_count == '0, "Empty status with entries.")
  `ILIE_ASSERT_SAME(a_full_count, rsp_full, int'(rsp_count) == CAPACITY, "Full below capacity.")

endmodule

bind indexed_list_insert_erase ilie_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_value(rsp.read_value),
  .rsp_status    (rsp.status),
  .rsp_count     (rsp.count)
);

@@ tb/tb_top.sv @@
module tb_top import ilie_pkg::*; ();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
  localparam int RANDOM_ITEMS = 1500;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    word_t   read_value;
    status_t status;
    count_t  count;
  } list_result_t;

  logic clk;
  logic rst;
  logic no_idle;

  ilie_req_if req_ch ();
  ilie_rsp_if rsp_ch ();

  indexed_list_insert_erase dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  entry_t       list_words [CAPACITY];
  int           list_len;
  int           peak_len;
  list_result_t pending_results [$];
  int           mismatch_count;
  int           items_accepted;
  int           results_checked;
  int           status_seen [4];
  int           cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    no_idle = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_APPEND;
    req_ch.index = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial cycle_count = 0;

  always @(negedge clk) begin
    rsp_ch.ready <= no_idle || ($urandom_range(99) >= 20);
  end

  function automatic entry_t to_entry(word_t v);
    return entry_t'(longint'(v));
  endfunction

  function automatic word_t from_entry(entry_t e);
    return word_t'(longint'(signed'(e)));
  endfunction

  function automatic list_result_t apply_list_op(mode_t m, index_t ix, word_t v);
    list_result_t r;
    int pos;
    r.read_value = '0;
    r.status = STATUS_OK;
    case (m)
      MODE_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          list_words[list_len] = to_entry(v);
          list_len++;
        end
      end
      MODE_POP: begin
        if (list_len > 0) list_len--;
      end
      MODE_INSERT: begin
        if (int'(ix) > list_len) begin
          r.status = STATUS_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          for (pos = list_len; pos > int'(ix); pos--) list_words[pos] = list_words[pos - 1];
          list_words[ix] = to_entry(v);
          list_len++;
        end
      end
      MODE_ERASE: begin
        if (int'(ix) >= list_len) begin
          r.status = STATUS_RANGE;
        end else begin
          for (pos = ix; pos + 1 < list_len; pos++) list_words[pos] = list_words[pos + 1];
          list_len--;
        end
      end
      MODE_READ: begin
        if (int'(ix) >= list_len) r.status = STATUS_RANGE;
        else r.read_value = from_entry(list_words[ix]);
      end
      MODE_FIRST: begin
        if (list_len == 0) r.status = STATUS_EMPTY;
        else r.read_value = from_entry(list_words[0]);
      end
      MODE_LAST: begin
        if (list_len == 0) r.status = STATUS_EMPTY;
        else r.read_value = from_entry(list_words[list_len - 1]);
      end
      MODE_CLEAR: begin
        list_len = 0;
      end
    endcase
    if (list_len > peak_len) peak_len = list_len;
    r.count = count_t'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_checked++;
      status_seen[rsp_ch.status]++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result read_value %0d status %0d count %0d", $time,
                   rsp_ch.read_value, rsp_ch.status, rsp_ch.count);
        end
      end else begin
        want = pending_results.pop_front();
        if (want.read_value !== rsp_ch.read_value || want.status !== rsp_ch.status ||
            want.count !== rsp_ch.count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: expected read_value %0d status %0d count %0d, got %0d %0d %0d",
                     $time, want.read_value, want.status, want.count,
                     rsp_ch.read_value, rsp_ch.status, rsp_ch.count);
          end
        end
      end
    end
  end

  task automatic send_item(mode_t m, index_t ix, word_t v);
    list_result_t next_result;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 20) begin
      req_ch.valid <= 1'b0;
      req_ch.mode <= mode_t'($urandom);
      req_ch.index <= index_t'($urandom);
      req_ch.value <= word_t'($urandom);
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= m;
    req_ch.index <= ix;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
    items_accepted++;
    next_result = apply_list_op(m, ix, v);
    pending_results = {pending_results, next_result};
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic index_t pick_index(int span);
    if ($urandom_range(9) == 0) return index_t'($urandom_range(127));
    if (span <= 0) return '0;
    return index_t'($urandom_range(span - 1));
  endfunction

  task automatic test_empty_list();
    send_item(MODE_POP, '0, '0);
    send_item(MODE_FIRST, '0, '0);
    send_item(MODE_LAST, '0, '0);
    send_item(MODE_READ, '0, '0);
    send_item(MODE_ERASE, '0, '0);
    send_item(MODE_INSERT, 7'd1, 32'sd5);
    send_item(MODE_READ, 7'd127, '0);
    send_item(MODE_CLEAR, '0, '0);
  endtask

  task automatic test_basic_ops();
    send_item(MODE_APPEND, '0, 32'sh7FFF_FFFF);
    send_item(MODE_APPEND, '0, 32'sh8000_0000);
    send_item(MODE_INSERT, 7'd0, -1);
    send_item(MODE_INSERT, 7'd3, '0);
    send_item(MODE_INSERT, 7'd1, 32'sh5A5A_A5A5);
    send_item(MODE_READ, 7'd0, '0);
    send_item(MODE_READ, 7'd4, '0);
    send_item(MODE_READ, 7'd5, '0);
    send_item(MODE_FIRST, '0, '0);
    send_item(MODE_LAST, '0, '0);
    send_item(MODE_ERASE, 7'd0, '0);
    send_item(MODE_ERASE, 7'd3, '0);
    send_item(MODE_ERASE, 7'd1, '0);
    send_item(MODE_READ, 7'd1, '0);
    send_item(MODE_POP, '0, '0);
    send_item(MODE_CLEAR, '0, '0);
    send_item(MODE_LAST, '0, '0);
  endtask

  task automatic test_full_list();
    int k;
    send_item(MODE_CLEAR, '0, '0);
    for (k = 0; k < CAPACITY; k++) begin
      if (k[0]) send_item(MODE_INSERT, index_t'($urandom_range(list_len)), pick_value());
      else send_item(MODE_APPEND, '0, pick_value());
    end
    send_item(MODE_APPEND, '0, 32'sd1);
    send_item(MODE_INSERT, 7'd64, 32'sd2);
    send_item(MODE_INSERT, 7'd0, 32'sd3);
    send_item(MODE_INSERT, 7'd65, 32'sd4);
    send_item(MODE_ERASE, 7'd64, '0);
    send_item(MODE_READ, 7'd63, '0);
    send_item(MODE_READ, 7'd64, '0);
    send_item(MODE_LAST, '0, '0);
    send_item(MODE_FIRST, '0, '0);
    send_item(MODE_ERASE, 7'd0, '0);
    send_item(MODE_INSERT, 7'd0, 32'sh8000_0000);
    send_item(MODE_ERASE, 7'd63, '0);
    send_item(MODE_APPEND, '0, 32'sh7FFF_FFFF);
    send_item(MODE_LAST, '0, '0);
  endtask

  task automatic test_random_ops(int n);
    int k;
    int phase;
    int roll;
    mode_t m;
    phase = 0;
    for (k = 0; k < n; k++) begin
      if (k % 100 == 0) phase = $urandom_range(2);
      no_idle = (k >= 600 && k < 900);
      roll = $urandom_range(99);
      case (phase)
        0: begin
          if (roll < 40) m = MODE_APPEND;
          else if (roll < 70) m = MODE_INSERT;
          else if (roll < 85) m = MODE_READ;
          else if (roll < 90) m = MODE_FIRST;
          else if (roll < 95) m = MODE_LAST;
          else if (roll < 98) m = MODE_ERASE;
          else m = MODE_POP;
        end
        1: begin
          if (roll < 30) m = MODE_ERASE;
          else if (roll < 55) m = MODE_POP;
          else if (roll < 70) m = MODE_READ;
          else if (roll < 78) m = MODE_FIRST;
          else if (roll < 86) m = MODE_LAST;
          else if (roll < 95) m = MODE_APPEND;
          else if (roll < 99) m = MODE_INSERT;
          else m = MODE_CLEAR;
        end
        default: begin
          m = mode_t'($urandom_range(7));
          if (m == MODE_CLEAR && roll >= 10) m = MODE_READ;
        end
      endcase
      if (m == MODE_INSERT) send_item(m, pick_index(list_len + 1), pick_value());
      else send_item(m, pick_index(list_len), pick_value());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    list_len = 0;
    peak_len = 0;
    mismatch_count = 0;
    items_accepted = 0;
    results_checked = 0;
    status_seen = '{default: 0};
    foreach (list_words[i]) list_words[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_ops(RANDOM_ITEMS);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d results; the list reached %0d of %0d entries.",
             items_accepted, results_checked, peak_len, CAPACITY);
    $display("Status seen: ok %0d, out of range %0d, empty %0d, full %0d.",
             status_seen[STATUS_OK], status_seen[STATUS_RANGE], status_seen[STATUS_EMPTY],
             status_seen[STATUS_FULL]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
